// ===== rtl/kt_pkg.sv =====
package kt_pkg;

   localparam int DataW  = 32;
   localparam int OpW    = 33;   // multiplier operand width (signed)
   localparam int NumW   = 56;   // divider dividend width
   localparam int DenW   = 34;   // divider divisor width
   localparam int MulR_W = 44;   // rounded product width

   localparam logic [31:0] ApnReset = 32'd16777;
   localparam logic [31:0] BpnReset = 32'd167772;
   localparam logic [31:0] MnReset  = 32'd1509949;

   localparam logic [1:0] CSR_APN = 2'd0;
   localparam logic [1:0] CSR_BPN = 2'd1;
   localparam logic [1:0] CSR_MN  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MUL,
      ST_DIV,
      ST_WB,
      ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_DT,
      OP_RATE,
      OP_DP,
      OP_P00,
      OP_P11,
      OP_K0,
      OP_K1,
      OP_ANG,
      OP_BIAS,
      OP_C00,
      OP_C01,
      OP_C10,
      OP_C11
   } op_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage

// ===== rtl/kalman_tilt_angle_filter.sv =====
// two-state kalman tilt filter for one axis: fuses a q16.16 accel angle and gyro rate into an
// angle estimate with gyro-bias tracking (covariances and noise settings q8.24). the first item
// after reset only primes the filter and returns zero. arithmetic runs bit-serially on one
// shared shift-add multiplier and one restoring divider, driven by a step sequencer. each
// product or quotient step runs setup, the serial multiply or divide, and writeback. a primed
// item holds req_stall high through all of its steps; when the innovation variance is not
// positive, the gain, correction and covariance update steps are skipped. a priming item
// goes straight to the output stage. the output stage waits only while an earlier result is
// still stalled. req_stall is high while an item is in work; the result sits in an output
// register so the next item is taken while it waits.
module kalman_tilt_angle_filter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [24:0]   req_accel_angle,
   input  logic signed [27:0]   req_gyro_rate,
   input  logic [15:0]          req_elapsed_ms,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_filtered_angle,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_wdata
);
   import kt_pkg::*;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   // configuration
   logic [31:0] apn_ff, bpn_ff, mn_ff;

   // filter state
   logic signed [31:0] ang_ff, ang_in, bias_ff, bias_in;
   logic signed [31:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   logic               primed_ff, primed_in;

   // latched item and temporaries
   logic signed [24:0] accel_ff;
   logic signed [27:0] rate_ff;
   logic [15:0]        ms_ff;
   logic signed [31:0] dt_ff, dt_in, dp_ff, dp_in, inner_ff, inner_in;
   logic signed [31:0] k0_ff, k0_in, k1_ff, k1_in, innov_ff, innov_in;
   logic signed [31:0] o00_ff, o00_in, o01_ff, o01_in;

   // serial multiplier
   logic [OpW-1:0] ma_ff, ma_in, mb_ff, mb_in, lo_ff, lo_in;
   logic [OpW:0]   hi_ff, hi_in, msum;
   logic           mneg_ff, mneg_in;
   logic [2*OpW:0]            prod;
   logic signed [2*OpW+1:0]   prod_s;
   logic signed [2*OpW+1:0]   prod_r;
   logic signed [MulR_W-1:0]  mul_r;

   // serial divider
   logic [NumW-1:0] num_ff, num_in;
   logic [DenW:0]   rem_ff, rem_in, rem_sh;
   logic [DenW-1:0] den_ff, den_in;
   logic            dneg_ff, dneg_in;
   logic signed [31:0] div_q;

   logic [5:0] cnt_ff, cnt_in;

   logic signed [31:0] rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // setup operands
   logic signed [OpW-1:0] opa, opb;
   logic                  is_div;
   logic [NumW-1:0]       dnum;
   logic [DenW-1:0]       dden;
   logic                  dsign;
   logic signed [DenW-1:0] s_val;
   logic signed [31:0]    rb;

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_angle = rsp_ff;

   assign s_val = DenW'(p00_ff) + DenW'(signed'({1'b0, mn_ff}));
   assign rb    = sat32(64'(rate_ff) - 64'(bias_ff));

   // product: magnitude, sign, round half up, floor shift
   assign msum   = hi_ff + (mb_ff[0] ? {1'b0, ma_ff} : '0);
   assign prod   = {hi_ff, lo_ff};
   assign prod_s = mneg_ff ? -signed'({1'b0, prod}) : signed'({1'b0, prod});
   assign prod_r = prod_s + (2*OpW+2)'(32'sd8388608);
   assign mul_r  = prod_r[24 +: MulR_W];

   assign rem_sh = {rem_ff[DenW-1:0], num_ff[NumW-1]};
   assign div_q  = dneg_ff ? sat32(-64'(signed'({8'b0, num_ff})))
                           : sat32(64'(signed'({8'b0, num_ff})));

   // operand select per step
   always_comb begin
      opa    = '0;
      opb    = '0;
      is_div = 1'b0;
      dnum   = '0;
      dden   = '0;
      dsign  = 1'b0;
      unique case (op_ff)
         OP_DT: begin
            is_div = 1'b1;
            dnum   = NumW'({ms_ff, 24'd0}) + NumW'(500);
            dden   = DenW'(1000);
         end
         OP_RATE: begin opa = OpW'(dt_ff); opb = OpW'(rb);       end
         OP_DP:   begin opa = OpW'(dt_ff); opb = OpW'(p11_ff);   end
         OP_P00:  begin opa = OpW'(dt_ff); opb = OpW'(inner_ff); end
         OP_P11:  begin opa = OpW'(dt_ff); opb = signed'({1'b0, bpn_ff}); end
         OP_K0: begin
            is_div = 1'b1;
            dsign  = p00_ff[31];
            dnum   = {NumW'(p00_ff[31] ? -33'(p00_ff) : 33'(p00_ff))} << 24;
            dden   = s_val;
         end
         OP_K1: begin
            is_div = 1'b1;
            dsign  = p10_ff[31];
            dnum   = {NumW'(p10_ff[31] ? -33'(p10_ff) : 33'(p10_ff))} << 24;
            dden   = s_val;
         end
         OP_ANG:  begin opa = OpW'(k0_ff); opb = OpW'(innov_ff); end
         OP_BIAS: begin opa = OpW'(k1_ff); opb = OpW'(innov_ff); end
         OP_C00:  begin opa = OpW'(k0_ff); opb = OpW'(o00_ff);   end
         OP_C01:  begin opa = OpW'(k0_ff); opb = OpW'(o01_ff);   end
         OP_C10:  begin opa = OpW'(k1_ff); opb = OpW'(o00_ff);   end
         OP_C11:  begin opa = OpW'(k1_ff); opb = OpW'(o01_ff);   end
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ang_in       = ang_ff;
      bias_in      = bias_ff;
      p00_in       = p00_ff;
      p01_in       = p01_ff;
      p10_in       = p10_ff;
      p11_in       = p11_ff;
      primed_in    = primed_ff;
      dt_in        = dt_ff;
      dp_in        = dp_ff;
      inner_in     = inner_ff;
      k0_in        = k0_ff;
      k1_in        = k1_ff;
      innov_in     = innov_ff;
      o00_in       = o00_ff;
      o01_in       = o01_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      mneg_in      = mneg_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      dneg_in      = dneg_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in = OP_DT;
               if (primed_ff) begin
                  state_in = ST_SETUP;
               end else begin
                  primed_in = 1'b1;
                  state_in  = ST_OUT;
               end
            end
         end
         ST_SETUP: begin
            cnt_in = '0;
            if (op_ff == OP_K0 && s_val <= 0) begin
               // no usable innovation variance: keep the predicted state
               state_in = ST_OUT;
            end else if (is_div) begin
               num_in   = dnum;
               den_in   = dden;
               rem_in   = '0;
               dneg_in  = dsign;
               state_in = ST_DIV;
            end else begin
               ma_in    = opa[OpW-1] ? -opa : opa;
               mb_in    = opb[OpW-1] ? -opb : opb;
               mneg_in  = opa[OpW-1] ^ opb[OpW-1];
               hi_in    = '0;
               lo_in    = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            hi_in  = {1'b0, msum[OpW:1]};
            lo_in  = {msum[0], lo_ff[OpW-1:1]};
            mb_in  = {1'b0, mb_ff[OpW-1:1]};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(OpW - 1)) begin
               state_in = ST_WB;
            end
         end
         ST_DIV: begin
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = rem_sh - {1'b0, den_ff};
               num_in = {num_ff[NumW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               num_in = {num_ff[NumW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(NumW - 1)) begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            state_in = ST_SETUP;
            op_in    = op_type'(op_ff + 4'd1);
            unique case (op_ff)
               OP_DT:   dt_in  = div_q;
               OP_RATE: ang_in = sat32(64'(ang_ff) + 64'(mul_r));
               OP_DP: begin
                  dp_in    = sat32(64'(mul_r));
                  inner_in = sat32(64'(mul_r) - 64'(p10_ff) - 64'(p01_ff)
                                   + 64'(signed'({1'b0, apn_ff})));
               end
               OP_P00: begin
                  p00_in = sat32(64'(p00_ff) + 64'(mul_r));
                  p01_in = sat32(64'(p01_ff) - 64'(dp_ff));
                  p10_in = sat32(64'(p10_ff) - 64'(dp_ff));
               end
               OP_P11:  p11_in = sat32(64'(p11_ff) + 64'(mul_r));
               OP_K0:   k0_in  = div_q;
               OP_K1: begin
                  k1_in    = div_q;
                  innov_in = sat32(64'(accel_ff) - 64'(ang_ff));
                  o00_in   = p00_ff;
                  o01_in   = p01_ff;
               end
               OP_ANG:  ang_in  = sat32(64'(ang_ff) + 64'(mul_r));
               OP_BIAS: bias_in = sat32(64'(bias_ff) + 64'(mul_r));
               OP_C00:  p00_in  = sat32(64'(p00_ff) - 64'(mul_r));
               OP_C01:  p01_in  = sat32(64'(p01_ff) - 64'(mul_r));
               OP_C10:  p10_in  = sat32(64'(p10_ff) - 64'(mul_r));
               OP_C11: begin
                  p11_in   = sat32(64'(p11_ff) - 64'(mul_r));
                  state_in = ST_OUT;
               end
               default: ;
            endcase
         end
         ST_OUT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = ang_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_DT;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ang_ff       <= '0;
         bias_ff      <= '0;
         p00_ff       <= '0;
         p01_ff       <= '0;
         p10_ff       <= '0;
         p11_ff       <= '0;
         apn_ff       <= ApnReset;
         bpn_ff       <= BpnReset;
         mn_ff        <= MnReset;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
         ang_ff       <= ang_in;
         bias_ff      <= bias_in;
         p00_ff       <= p00_in;
         p01_ff       <= p01_in;
         p10_ff       <= p10_in;
         p11_ff       <= p11_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_APN: apn_ff <= csr_wdata;
               CSR_BPN: bpn_ff <= csr_wdata;
               CSR_MN:  mn_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload and datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         accel_ff <= req_accel_angle;
         rate_ff  <= req_gyro_rate;
         ms_ff    <= req_elapsed_ms;
      end
      dt_in_reg: begin
         dt_ff    <= dt_in;
         dp_ff    <= dp_in;
         inner_ff <= inner_in;
         k0_ff    <= k0_in;
         k1_ff    <= k1_in;
         innov_ff <= innov_in;
         o00_ff   <= o00_in;
         o01_ff   <= o01_in;
         ma_ff    <= ma_in;
         mb_ff    <= mb_in;
         hi_ff    <= hi_in;
         lo_ff    <= lo_in;
         mneg_ff  <= mneg_in;
         num_ff   <= num_in;
         rem_ff   <= rem_in;
         den_ff   <= den_in;
         dneg_ff  <= dneg_in;
         cnt_ff   <= cnt_in;
         rsp_ff   <= rsp_in;
      end
   end

endmodule

// ===== rtl/kt_checker.sv =====
module kt_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_filtered_angle
);

   // an accepted item raises req_stall in the cycle after the accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after accept");

   // reset leaves no result pending
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_filtered_angle)))
      else $error("stalled result changed");

endmodule

bind kalman_tilt_angle_filter kt_checker u_kt_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_filtered_angle (rsp_filtered_angle)
);
